[src/chte_pkg.sv]
// Shared types, constants and helpers for the chained hash table engine.
// Used by every module in src; depends on nothing.
package chte_pkg;

    // Table geometry
    localparam int MAX_BUCKETS  = 1024;
    localparam int POOL_ENTRIES = 1024;
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int ENT_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int USED_W = $clog2(POOL_ENTRIES + 1);

    // Field widths
    localparam int CNT_W  = 11;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // Bit-serial remainder unit
    localparam int DIV_STEPS = KEY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REWIND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value_out;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_CHANGE,
        OP_REWIND,
        OP_NEXT,
        OP_BAD
    } op_t;

    // Classified job handed from front to back
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } job_t;

    // Nullable pointer into the entry pool
    typedef struct packed {
        logic             valid;
        logic [ENT_W-1:0] idx;
    } ptr_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HREAD,
        ST_HCHK,
        ST_ECHK,
        ST_NCHK,
        ST_SEEK,
        ST_SCHK,
        ST_RESP
    } state_t;

    function automatic op_t classify(input logic [CMD_W-1:0] cmd);
        op_t op;
        unique case (cmd)
            CMD_LOOKUP: op = OP_LOOKUP;
            CMD_INSERT: op = OP_INSERT;
            CMD_CHANGE: op = OP_CHANGE;
            CMD_REWIND: op = OP_REWIND;
            CMD_NEXT:   op = OP_NEXT;
            default:    op = OP_BAD;
        endcase
        return op;
    endfunction

    // Zero acts as one, anything above the table size as the table size
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_BUCKETS) begin
            r = CNT_W'(MAX_BUCKETS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/chte_front.sv]
// Front end: accepts input transfers, classifies the command and queues the job.
// Depends on chte_pkg.
module chte_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chte_pkg::in_item_t  s_data,
    input  logic                clearing,
    output logic                q_valid,
    output chte_pkg::job_t      q_job,
    input  logic                q_pop
);

    chte_pkg::job_t              q_mem [chte_pkg::QDEPTH];
    logic [chte_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [chte_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [chte_pkg::QPTR_W:0]   cnt_reg;
    logic                        push;
    chte_pkg::job_t              job_in;

    // No new work while the head table is being swept
    assign s_ready = (cnt_reg != (chte_pkg::QPTR_W+1)'(chte_pkg::QDEPTH)) && !clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_job   = q_mem[rd_ptr_reg];

    // Decode command into an operation class
    always_comb begin
        job_in.op    = chte_pkg::classify(s_data.command);
        job_in.key   = s_data.key;
        job_in.value = s_data.value_in;
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[src/chte_mod.sv]
// Bit-serial remainder unit: key modulo bucket count, one key bit per cycle.
// Depends on chte_pkg.
module chte_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [chte_pkg::KEY_W-1:0]    dividend,
    input  logic [chte_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [chte_pkg::BKT_W-1:0]    remainder
);

    logic [chte_pkg::KEY_W-1:0]  dvd_reg;
    logic [chte_pkg::CNT_W-1:0]  rem_reg;
    logic [chte_pkg::STEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [chte_pkg::CNT_W:0]    trial;
    logic [chte_pkg::CNT_W:0]    rem_next;

    // Shift in the next key bit and subtract if it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[chte_pkg::KEY_W-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = trial - {1'b0, divisor};
        end else begin
            rem_next = trial;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[chte_pkg::BKT_W-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[chte_pkg::KEY_W-2:0], 1'b0};
            rem_reg <= rem_next[chte_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == chte_pkg::STEP_W'(chte_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/chte_back.sv]
// Back end: sequencer, bucket head and entry pool memories, iterator and result register.
// Depends on chte_pkg and chte_mod.
module chte_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [chte_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                           q_valid,
    input  chte_pkg::job_t                 q_job,
    output logic                           q_pop,
    output logic                           clearing,
    output logic                           m_valid,
    input  logic                           m_ready,
    output chte_pkg::out_item_t            m_data
);

    // Memories
    chte_pkg::ptr_t             heads_mem [chte_pkg::MAX_BUCKETS];
    logic [chte_pkg::KEY_W-1:0] keys_mem  [chte_pkg::POOL_ENTRIES];
    logic [chte_pkg::VAL_W-1:0] vals_mem  [chte_pkg::POOL_ENTRIES];
    chte_pkg::ptr_t             links_mem [chte_pkg::POOL_ENTRIES];

    chte_pkg::state_t state_reg, state_next;

    logic [chte_pkg::CNT_W-1:0]  count_reg;
    logic [chte_pkg::BKT_W-1:0]  clr_addr_reg;
    logic [chte_pkg::USED_W-1:0] used_reg;
    logic                        iter_valid_reg;
    logic [chte_pkg::CNT_W-1:0]  iter_bucket_reg;
    logic [chte_pkg::ENT_W-1:0]  iter_entry_reg;
    logic [chte_pkg::CNT_W-1:0]  seek_reg;
    chte_pkg::op_t               op_reg;
    logic [chte_pkg::KEY_W-1:0]  key_reg;
    logic [chte_pkg::VAL_W-1:0]  val_reg;
    logic [chte_pkg::BKT_W-1:0]  bkt_reg;
    logic [chte_pkg::ENT_W-1:0]  cur_reg;
    chte_pkg::ptr_t              head_save_reg;
    logic [chte_pkg::STAT_W-1:0] res_status_reg;
    logic [chte_pkg::VAL_W-1:0]  res_value_reg;

    // Read data, registered
    chte_pkg::ptr_t             head_rdata_reg;
    logic [chte_pkg::KEY_W-1:0] key_rdata_reg;
    logic [chte_pkg::VAL_W-1:0] val_rdata_reg;
    chte_pkg::ptr_t             link_rdata_reg;

    // Memory controls
    logic [chte_pkg::BKT_W-1:0] head_raddr;
    logic                       head_we;
    logic [chte_pkg::BKT_W-1:0] head_waddr;
    chte_pkg::ptr_t             head_wdata;
    logic [chte_pkg::ENT_W-1:0] ent_raddr;
    logic                       alloc_we;
    logic                       val_we;
    logic [chte_pkg::ENT_W-1:0] val_waddr;
    chte_pkg::ptr_t             link_wdata;
    logic [chte_pkg::ENT_W-1:0] alloc_idx;

    // Remainder unit
    logic                       mod_start;
    logic                       mod_done;
    logic [chte_pkg::BKT_W-1:0] mod_rem;

    // Chain search outcome
    logic hit;
    logic miss;
    logic next_ok;
    logic pool_full;

    // The key is taken straight from the queue head at the pop edge
    chte_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (q_job.key),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign alloc_idx = used_reg[chte_pkg::ENT_W-1:0];
    assign pool_full = (used_reg >= chte_pkg::USED_W'(chte_pkg::POOL_ENTRIES));
    assign hit  = (state_reg == chte_pkg::ST_ECHK) && (key_rdata_reg == key_reg);
    assign miss = ((state_reg == chte_pkg::ST_HCHK) && !head_rdata_reg.valid)
               || ((state_reg == chte_pkg::ST_ECHK) && (key_rdata_reg != key_reg)
                   && !link_rdata_reg.valid);
    assign next_ok = iter_valid_reg
                  && ({{(chte_pkg::USED_W-chte_pkg::ENT_W){1'b0}}, iter_entry_reg} < used_reg);

    assign clearing = (state_reg == chte_pkg::ST_CLEAR);
    assign m_valid  = (state_reg == chte_pkg::ST_RESP);
    assign m_data.status    = res_status_reg;
    assign m_data.value_out = res_value_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            chte_pkg::ST_CLEAR: begin
                if (clr_addr_reg == chte_pkg::BKT_W'(chte_pkg::MAX_BUCKETS - 1)) begin
                    state_next = chte_pkg::ST_IDLE;
                end
            end
            chte_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_job.op)
                        chte_pkg::OP_LOOKUP,
                        chte_pkg::OP_INSERT,
                        chte_pkg::OP_CHANGE: state_next = chte_pkg::ST_MOD;
                        chte_pkg::OP_REWIND: state_next = chte_pkg::ST_SEEK;
                        chte_pkg::OP_NEXT:
                            state_next = next_ok ? chte_pkg::ST_NCHK : chte_pkg::ST_RESP;
                        default:             state_next = chte_pkg::ST_RESP;
                    endcase
                end
            end
            chte_pkg::ST_MOD: begin
                if (mod_done) begin
                    state_next = chte_pkg::ST_HREAD;
                end
            end
            chte_pkg::ST_HREAD: state_next = chte_pkg::ST_HCHK;
            chte_pkg::ST_HCHK: begin
                state_next = miss ? chte_pkg::ST_RESP : chte_pkg::ST_ECHK;
            end
            chte_pkg::ST_ECHK: begin
                if (hit || miss) begin
                    state_next = chte_pkg::ST_RESP;
                end
            end
            chte_pkg::ST_NCHK: begin
                state_next = link_rdata_reg.valid ? chte_pkg::ST_RESP : chte_pkg::ST_SEEK;
            end
            chte_pkg::ST_SEEK: begin
                state_next = (seek_reg >= count_reg) ? chte_pkg::ST_RESP : chte_pkg::ST_SCHK;
            end
            chte_pkg::ST_SCHK: begin
                state_next = head_rdata_reg.valid ? chte_pkg::ST_RESP : chte_pkg::ST_SEEK;
            end
            chte_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = chte_pkg::ST_IDLE;
                end
            end
            default: state_next = chte_pkg::ST_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb begin
        q_pop      = (state_reg == chte_pkg::ST_IDLE) && q_valid;
        mod_start  = q_pop && ((q_job.op == chte_pkg::OP_LOOKUP)
                            || (q_job.op == chte_pkg::OP_INSERT)
                            || (q_job.op == chte_pkg::OP_CHANGE));
        head_raddr = (state_reg == chte_pkg::ST_HREAD) ? mod_rem
                                                       : seek_reg[chte_pkg::BKT_W-1:0];
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = '{valid: 1'b1, idx: alloc_idx};
        ent_raddr  = iter_entry_reg;
        alloc_we   = 1'b0;
        val_we     = 1'b0;
        val_waddr  = alloc_idx;
        link_wdata = (state_reg == chte_pkg::ST_HCHK) ? head_rdata_reg : head_save_reg;

        if (state_reg == chte_pkg::ST_CLEAR) begin
            head_we    = 1'b1;
            head_waddr = clr_addr_reg;
            head_wdata = '0;
        end
        if (state_reg == chte_pkg::ST_HCHK) begin
            ent_raddr = head_rdata_reg.idx;
        end else if (state_reg == chte_pkg::ST_ECHK) begin
            ent_raddr = link_rdata_reg.idx;
        end

        // Insert of a new key goes to the head of its chain
        if (miss && (op_reg == chte_pkg::OP_INSERT) && !pool_full) begin
            alloc_we = 1'b1;
            val_we   = 1'b1;
            head_we  = 1'b1;
        end
        if (hit && (op_reg == chte_pkg::OP_CHANGE)) begin
            val_we    = 1'b1;
            val_waddr = cur_reg;
        end
    end

    // Bucket head memory
    always_ff @(posedge aclk) begin
        if (head_we) begin
            heads_mem[head_waddr] <= head_wdata;
        end
        head_rdata_reg <= heads_mem[head_raddr];
    end

    // Entry pool memories
    always_ff @(posedge aclk) begin
        if (alloc_we) begin
            keys_mem[alloc_idx]  <= key_reg;
            links_mem[alloc_idx] <= link_wdata;
        end
        if (val_we) begin
            vals_mem[val_waddr] <= val_reg;
        end
        key_rdata_reg  <= keys_mem[ent_raddr];
        val_rdata_reg  <= vals_mem[ent_raddr];
        link_rdata_reg <= links_mem[ent_raddr];
    end

    // State register; a configuration write restarts the head sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chte_pkg::ST_CLEAR;
        end else if (cfg_we) begin
            state_reg <= chte_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= chte_pkg::clamp_count(chte_pkg::CNT_W'(chte_pkg::MAX_BUCKETS));
            clr_addr_reg    <= '0;
            used_reg        <= '0;
            iter_valid_reg  <= 1'b0;
            iter_bucket_reg <= '0;
            iter_entry_reg  <= '0;
        end else if (cfg_we) begin
            count_reg       <= chte_pkg::clamp_count(cfg_wdata);
            clr_addr_reg    <= '0;
            used_reg        <= '0;
            iter_valid_reg  <= 1'b0;
            iter_bucket_reg <= '0;
        end else begin
            if (state_reg == chte_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (alloc_we) begin
                used_reg <= used_reg + 1'b1;
            end
            if (q_pop && (q_job.op == chte_pkg::OP_NEXT) && !next_ok) begin
                iter_valid_reg <= 1'b0;
            end
            if ((state_reg == chte_pkg::ST_NCHK) && link_rdata_reg.valid) begin
                iter_entry_reg <= link_rdata_reg.idx;
            end
            if ((state_reg == chte_pkg::ST_SEEK) && (seek_reg >= count_reg)) begin
                iter_bucket_reg <= count_reg;
                iter_valid_reg  <= 1'b0;
            end
            if ((state_reg == chte_pkg::ST_SCHK) && head_rdata_reg.valid) begin
                iter_bucket_reg <= seek_reg;
                iter_entry_reg  <= head_rdata_reg.idx;
                iter_valid_reg  <= 1'b1;
            end
        end
    end

    // Job and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg         <= q_job.op;
            key_reg        <= q_job.key;
            val_reg        <= q_job.value;
            seek_reg       <= '0;
            res_value_reg  <= '0;
            res_status_reg <= (q_job.op == chte_pkg::OP_REWIND) ? chte_pkg::STAT_OK
                                                                : chte_pkg::STAT_MISS;
        end
        if (state_reg == chte_pkg::ST_HREAD) begin
            bkt_reg <= mod_rem;
        end
        if (state_reg == chte_pkg::ST_HCHK) begin
            head_save_reg <= head_rdata_reg;
            cur_reg       <= head_rdata_reg.idx;
        end
        if ((state_reg == chte_pkg::ST_ECHK) && !hit) begin
            cur_reg <= link_rdata_reg.idx;
        end
        if (state_reg == chte_pkg::ST_NCHK) begin
            res_status_reg <= chte_pkg::STAT_OK;
            res_value_reg  <= val_rdata_reg;
            seek_reg       <= iter_bucket_reg + 1'b1;
        end
        if ((state_reg == chte_pkg::ST_SCHK) && !head_rdata_reg.valid) begin
            seek_reg <= seek_reg + 1'b1;
        end
        // Chain search outcome
        if (hit) begin
            res_status_reg <= (op_reg == chte_pkg::OP_INSERT) ? chte_pkg::STAT_DUP
                                                              : chte_pkg::STAT_OK;
            if (op_reg == chte_pkg::OP_LOOKUP) begin
                res_value_reg <= val_rdata_reg;
            end
        end else if (miss) begin
            if (op_reg == chte_pkg::OP_INSERT) begin
                res_status_reg <= pool_full ? chte_pkg::STAT_FULL : chte_pkg::STAT_OK;
            end else begin
                res_status_reg <= chte_pkg::STAT_MISS;
            end
        end
    end

endmodule

[src/chained_hash_table_engine.sv]
// Top level of the chained hash table engine: front queue plus back sequencer.
// Depends on chte_pkg, chte_front and chte_back.
//
//  channel   ports                      direction  payload
//  input     s_valid s_ready s_data     in         in_item_t (command, key, value_in)
//  result    m_valid m_ready m_data     out        out_item_t (status, value_out)
//  config    cfg_we cfg_wdata           in         bucket_count, 11 bits
//
// In lookup, insert and change the remainder unit retires one key bit per cycle; then the
// bucket head is read and the chain is walked one entry at a time. Rewind and next step
// through empty buckets one at a time, SEEK then SCHK, via the one head memory read port.
// After reset and after every bucket_count write the whole head table is swept and s_ready
// stays low. A stalled result holds the back end; the front queue of two jobs keeps
// taking transfers meanwhile, until it is full.
module chained_hash_table_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  chte_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output chte_pkg::out_item_t           m_data,
    input  logic                          cfg_we,
    input  logic [chte_pkg::CNT_W-1:0]    cfg_wdata
);

    logic           q_valid;
    chte_pkg::job_t q_job;
    logic           q_pop;
    logic           clearing;

    chte_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop)
    );

    chte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // No input transfer during the head sweep
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("input accepted during head sweep");

    // A configuration write drops any pending result
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (!m_valid && clearing))
        else $error("configuration write did not restart sweep");

    // Value is zero unless status is ok
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != chte_pkg::STAT_OK)) |-> (m_data.value_out == '0))
        else $error("nonzero value with error status");

endmodule
